// File: hw/rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

   // Default sizing
   localparam int MAX_KEPT_DEF   = 64;
   localparam int COORD_BITS_DEF = 16;

   // IoU threshold register, Q1.8
   localparam int             THR_W               = 9;
   localparam int             IOU_FRAC_BITS       = 8;
   localparam logic [THR_W-1:0] IOU_THRESHOLD_RESET = 9'd115;

   // Running box position within a frame, saturating
   localparam int                INDEX_W   = 16;
   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

   // Compare pipeline back to the sequencer
   typedef struct packed {
      logic busy;   // a kept box is still in flight
      logic hit;    // a kept box suppresses the current one
   } gbn_status_type;

   // Decision for one box
   typedef struct packed {
      logic               keep;
      logic               overflow;
      logic [INDEX_W-1:0] box_index;
   } gbn_result_type;

endpackage

// File: hw/rtl/greedy_box_nms.sv
`timescale 1ns / 1ps

// Streaming greedy non-maximum suppression. Feed boxes sorted by falling
// score, one beat each; frame_start on a beat empties the kept list and
// restarts box_index. Each box is tested against every kept box of its
// frame through one pipelined IoU compare unit that takes one kept box per
// cycle; the test is inter*256 > iou_threshold*union, so no divider is used.
// A box that survives is appended to the kept store; if the store already
// holds MAX_KEPT boxes the result shows keep and overflow and the box is
// not stored. One input beat gives exactly one result beat. The result beat
// is decided after the area is computed, one store read is made per kept
// box, and the store read register and the four compare stages drain; an
// empty kept list skips the reads. The next box can be taken once the
// decision is loaded into the output register, so each box waits for the
// compare of every kept box, MAX_KEPT with a full store. req_stall
// stays high while an item is in work. The result sits in an output
// register, so the next box is accepted while the previous result waits.
// Write iou_threshold (Q1.8, reset 115) only while the block is idle.

module greedy_box_nms #(
   parameter int MAX_KEPT   = gbn_pkg::MAX_KEPT_DEF,
   parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // box beats
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_frame_start,
   input  logic signed [COORD_BITS-1:0]       req_box_left,
   input  logic signed [COORD_BITS-1:0]       req_box_top,
   input  logic [COORD_BITS-1:0]              req_box_width,
   input  logic [COORD_BITS-1:0]              req_box_height,
   // result beats
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_keep,
   output logic [gbn_pkg::INDEX_W-1:0]        rsp_box_index,
   output logic                               rsp_overflow,
   // threshold register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbn_pkg::THR_W-1:0]          csr_iou_threshold
);

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int C  = COORD_BITS;

   logic [gbn_pkg::THR_W-1:0] thr_ff;

   logic signed [C-1:0] cur_left, cur_top;
   logic [C-1:0]        cur_width, cur_height;
   logic [2*C-1:0]      cur_area;

   logic            rd_en, wr_en, rd_valid;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic [4*C-1:0]  wr_data, rd_data;

   gbn_pkg::gbn_status_type status;
   gbn_pkg::gbn_result_type res;
   logic                    res_valid;
   logic                    rsp_free;

   logic                         rsp_valid_ff;
   logic                         rsp_keep_ff;
   logic                         rsp_overflow_ff;
   logic [gbn_pkg::INDEX_W-1:0]  rsp_box_index_ff;

   // Threshold always ready; the user writes only while idle, not enforced
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbn_pkg::IOU_THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_iou_threshold;
      end
   end

   // Sequencer: take a box, compute its area, walk the kept list, decide
   gbn_ctrl #(
      .MAX_KEPT   (MAX_KEPT),
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_box_left    (req_box_left),
      .req_box_top     (req_box_top),
      .req_box_width   (req_box_width),
      .req_box_height  (req_box_height),
      .cur_left_ff     (cur_left),
      .cur_top_ff      (cur_top),
      .cur_width_ff    (cur_width),
      .cur_height_ff   (cur_height),
      .cur_area_ff     (cur_area),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .status          (status),
      .rsp_free        (rsp_free),
      .res_valid       (res_valid),
      .res             (res)
   );

   // Kept boxes of the current frame; entries past kept_count are never read
   gbn_kept_store #(
      .DEPTH  (MAX_KEPT),
      .DATA_W (4 * C)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data_ff  (rd_data),
      .rd_valid_ff (rd_valid)
   );

   // Shared IoU compare pipeline, one kept box per cycle
   gbn_iou_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_iou (
      .clock      (clock),
      .reset      (reset),
      .thr        (thr_ff),
      .cur_left   (cur_left),
      .cur_top    (cur_top),
      .cur_width  (cur_width),
      .cur_height (cur_height),
      .cur_area   (cur_area),
      .rd_valid   (rd_valid),
      .rd_data    (rd_data),
      .status     (status)
   );

   // Output register: load a decision when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff     <= 1'b1;
         rsp_keep_ff      <= res.keep;
         rsp_overflow_ff  <= res.overflow;
         rsp_box_index_ff <= res.box_index;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_keep      = rsp_keep_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign rsp_box_index = rsp_box_index_ff;

endmodule

// File: hw/rtl/gbn_kept_store.sv
`timescale 1ns / 1ps

module gbn_kept_store #(
   parameter int   DEPTH  = gbn_pkg::MAX_KEPT_DEF,
   parameter int   DATA_W = 4 * gbn_pkg::COORD_BITS_DEF,
   localparam int  AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data_ff,
   output logic              rd_valid_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

endmodule

// File: hw/rtl/gbn_iou_unit.sv
`timescale 1ns / 1ps

module gbn_iou_unit #(
   parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gbn_pkg::THR_W-1:0]     thr,
   input  logic signed [COORD_BITS-1:0]  cur_left,
   input  logic signed [COORD_BITS-1:0]  cur_top,
   input  logic [COORD_BITS-1:0]         cur_width,
   input  logic [COORD_BITS-1:0]         cur_height,
   input  logic [2*COORD_BITS-1:0]       cur_area,
   input  logic                          rd_valid,
   input  logic [4*COORD_BITS-1:0]       rd_data,
   output gbn_pkg::gbn_status_type       status
);

   localparam int C      = COORD_BITS;
   localparam int EW     = C + 2;                  // edge width, left + width
   localparam int AREA_W = 2 * C;
   localparam int UW     = AREA_W + 1;             // union width
   localparam int PW     = UW + gbn_pkg::THR_W;    // product width

   // Kept box fields
   logic signed [C-1:0] b_left;
   logic signed [C-1:0] b_top;
   logic [C-1:0]        b_width;
   logic [C-1:0]        b_height;

   // Edges
   logic signed [EW-1:0] a_l, a_r, a_t, a_b;
   logic signed [EW-1:0] k_l, k_r, k_t, k_b;
   logic signed [EW-1:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
   logic [C-1:0]         span_x, span_y;

   // Stage registers
   logic              s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [C-1:0]      span_x_ff, span_y_ff, bw_ff, bh_ff;
   logic [AREA_W-1:0] inter_ff, b_area_ff, inter3_ff;
   logic [UW-1:0]     union_ff;
   logic              hit_ff;

   logic [PW-1:0] lhs, rhs;

   assign b_left   = signed'(rd_data[4*C-1:3*C]);
   assign b_top    = signed'(rd_data[3*C-1:2*C]);
   assign b_width  = rd_data[2*C-1:C];
   assign b_height = rd_data[C-1:0];

   assign a_l = EW'(cur_left);
   assign a_t = EW'(cur_top);
   assign a_r = a_l + signed'(EW'(cur_width));
   assign a_b = a_t + signed'(EW'(cur_height));
   assign k_l = EW'(b_left);
   assign k_t = EW'(b_top);
   assign k_r = k_l + signed'(EW'(b_width));
   assign k_b = k_t + signed'(EW'(b_height));

   assign lo_x = (a_l > k_l) ? a_l : k_l;
   assign hi_x = (a_r < k_r) ? a_r : k_r;
   assign lo_y = (a_t > k_t) ? a_t : k_t;
   assign hi_y = (a_b < k_b) ? a_b : k_b;
   assign dx   = hi_x - lo_x;
   assign dy   = hi_y - lo_y;

   // Overlap span never exceeds either width, so C bits hold it
   assign span_x = (hi_x > lo_x && hi_y > lo_y) ? dx[C-1:0] : '0;
   assign span_y = (hi_x > lo_x && hi_y > lo_y) ? dy[C-1:0] : '0;

   // inter * 256 against thr * union
   assign lhs = PW'({inter3_ff, gbn_pkg::IOU_FRAC_BITS'(0)});
   assign rhs = PW'(thr) * PW'(union_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rd_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
      // stage 1: overlap spans
      span_x_ff <= span_x;
      span_y_ff <= span_y;
      bw_ff     <= b_width;
      bh_ff     <= b_height;
      // stage 2: intersection and kept area
      inter_ff  <= AREA_W'(span_x_ff) * AREA_W'(span_y_ff);
      b_area_ff <= AREA_W'(bw_ff) * AREA_W'(bh_ff);
      // stage 3: union
      union_ff  <= UW'(cur_area) + UW'(b_area_ff) - UW'(inter_ff);
      inter3_ff <= inter_ff;
      // stage 4: threshold test
      hit_ff    <= lhs > rhs;
   end

   assign status.busy = rd_valid | s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff;
   assign status.hit  = s4_v_ff & hit_ff;

endmodule

// File: hw/rtl/gbn_ctrl.sv
`timescale 1ns / 1ps

module gbn_ctrl #(
   parameter int  MAX_KEPT   = gbn_pkg::MAX_KEPT_DEF,
   parameter int  COORD_BITS = gbn_pkg::COORD_BITS_DEF,
   localparam int AW         = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_frame_start,
   input  logic signed [COORD_BITS-1:0]  req_box_left,
   input  logic signed [COORD_BITS-1:0]  req_box_top,
   input  logic [COORD_BITS-1:0]         req_box_width,
   input  logic [COORD_BITS-1:0]         req_box_height,
   output logic signed [COORD_BITS-1:0]  cur_left_ff,
   output logic signed [COORD_BITS-1:0]  cur_top_ff,
   output logic [COORD_BITS-1:0]         cur_width_ff,
   output logic [COORD_BITS-1:0]         cur_height_ff,
   output logic [2*COORD_BITS-1:0]       cur_area_ff,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [4*COORD_BITS-1:0]       wr_data,
   input  gbn_pkg::gbn_status_type       status,
   input  logic                          rsp_free,
   output logic                          res_valid,
   output gbn_pkg::gbn_result_type       res
);

   localparam int CW     = $clog2(MAX_KEPT + 1);
   localparam int AREA_W = 2 * COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type                    state_ff;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                idx_ff;
   logic [gbn_pkg::INDEX_W-1:0]  frame_idx_ff;
   logic                         suppress_ff;
   logic                         full;
   logic                         finish;

   assign full      = (count_ff == CW'(MAX_KEPT));
   assign finish    = (state_ff == ST_DECIDE) && rsp_free;
   assign req_stall = (state_ff != ST_IDLE);

   assign rd_en   = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign rd_addr = idx_ff[AW-1:0];

   assign wr_en   = finish && !suppress_ff && !full;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = {cur_left_ff, cur_top_ff, cur_width_ff, cur_height_ff};

   assign res_valid     = finish;
   assign res.keep      = !suppress_ff;
   assign res.overflow  = !suppress_ff && full;
   assign res.box_index = frame_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         frame_idx_ff <= '0;
         suppress_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cur_left_ff   <= req_box_left;
                  cur_top_ff    <= req_box_top;
                  cur_width_ff  <= req_box_width;
                  cur_height_ff <= req_box_height;
                  suppress_ff   <= 1'b0;
                  if (req_frame_start) begin
                     count_ff     <= '0;
                     frame_idx_ff <= '0;
                  end
                  state_ff <= ST_AREA;
               end
            end
            ST_AREA: begin
               cur_area_ff <= AREA_W'(cur_width_ff) * AREA_W'(cur_height_ff);
               idx_ff      <= '0;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               if (idx_ff < count_ff) begin
                  idx_ff <= idx_ff + CW'(1);
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!status.busy) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (rsp_free) begin
                  if (!suppress_ff && !full) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  if (frame_idx_ff != gbn_pkg::INDEX_MAX) begin
                     frame_idx_ff <= frame_idx_ff + gbn_pkg::INDEX_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (status.hit) begin
            suppress_ff <= 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/gbn_checker.sv
`timescale 1ns / 1ps

module gbn_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_keep,
   input logic [gbn_pkg::INDEX_W-1:0]       rsp_box_index,
   input logic                              rsp_overflow
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_box_index))
      else $error("result beat dropped or changed while stalled");

   // Overflow only on a box that survives suppression
   a_ovf_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_keep || !rsp_overflow))
      else $error("overflow flagged on a suppressed box");

   // Stall input right after taking a box
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the box was decided");

   // A new result appears only out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a box in work");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Stand-alone bench for greedy_box_nms.
//
// Boxes go in one beat at a time and every accepted beat is run through a
// behavioral copy of the greedy suppression scheme kept in this file. That
// copy holds its own kept list, box position and IoU threshold. It queues
// the decision it expects, and a monitor pops and compares each result beat
// against it field by field.
//
// The run walks through these parts in order:
//   - hand-picked frames
//   - threshold corner cases
//   - a frame that overruns the kept store
//   - a long receiver hold-off
//   - randomized frames under four idling mixes

module testbench;

   localparam int CB           = gbn_pkg::COORD_BITS_DEF;
   localparam int KEPT_DEPTH   = gbn_pkg::MAX_KEPT_DEF;
   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int HOLD_OFF     = 400;

   typedef struct {
      logic signed [CB-1:0] left;
      logic signed [CB-1:0] top;
      logic [CB-1:0]        width;
      logic [CB-1:0]        height;
   } rect_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_frame_start = 1'b0;
   logic signed [CB-1:0]          req_box_left = '0;
   logic signed [CB-1:0]          req_box_top = '0;
   logic [CB-1:0]                 req_box_width = '0;
   logic [CB-1:0]                 req_box_height = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_keep;
   logic [gbn_pkg::INDEX_W-1:0]   rsp_box_index;
   logic                          rsp_overflow;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [gbn_pkg::THR_W-1:0]     csr_iou_threshold = '0;

   // Behavioral copy of the block state.
   rect_type                      kept_rects[KEPT_DEPTH];
   int                            kept_total = 0;
   logic [gbn_pkg::INDEX_W-1:0]   frame_pos = '0;
   logic [gbn_pkg::THR_W-1:0]     thr_now = gbn_pkg::IOU_THRESHOLD_RESET;

   // Decisions waiting for their result beat, oldest first.
   gbn_pkg::gbn_result_type       pending_verdicts[$];
   gbn_pkg::gbn_result_type       head;

   int                            fault_count = 0;
   int                            cycle_count = 0;
   int                            sender_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   int unsigned                   hold_cycles = 0;

   greedy_box_nms #(
      .MAX_KEPT   (KEPT_DEPTH),
      .COORD_BITS (CB)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_start   (req_frame_start),
      .req_box_left      (req_box_left),
      .req_box_top       (req_box_top),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_keep          (rsp_keep),
      .rsp_box_index     (rsp_box_index),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_iou_threshold (csr_iou_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver side. A pending hold-off wins over the random stall draw; count
   // it down here so the sender keeps pushing while results back up.
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t ns: %s", $time, msg);
   endfunction

   // Monitor: take each result beat and match it to the oldest decision.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            note_fault($sformatf("result with nothing pending: keep=%0b index=%0d overflow=%0b",
                                 rsp_keep, rsp_box_index, rsp_overflow));
         end else begin
            head = pending_verdicts.pop_front();
            if (rsp_keep !== head.keep || rsp_box_index !== head.box_index ||
                rsp_overflow !== head.overflow)
               note_fault($sformatf({"result mismatch: keep exp %0b got %0b, index exp %0d ",
                                     "got %0d, overflow exp %0b got %0b"},
                                    head.keep, rsp_keep, head.box_index, rsp_box_index,
                                    head.overflow, rsp_overflow));
         end
      end
   end

   // Greedy suppression of one box against the kept list of its frame.
   // Work in 64-bit so edges past the coordinate range and the scaled
   // products stay exact.
   function automatic gbn_pkg::gbn_result_type judge_box(input logic fs, input rect_type r);
      gbn_pkg::gbn_result_type v;
      longint         area_r;
      longint         area_k;
      longint         inter;
      longint         uni;
      longint         lo_x;
      longint         lo_y;
      longint         hi_x;
      longint         hi_y;
      logic           keep_it;
      keep_it = 1'b1;
      if (fs) begin
         kept_total = 0;
         frame_pos  = '0;
      end
      area_r = longint'(r.width) * longint'(r.height);
      for (int k = 0; k < kept_total; k++) begin
         lo_x = (r.left > kept_rects[k].left) ? longint'(r.left) : longint'(kept_rects[k].left);
         lo_y = (r.top > kept_rects[k].top) ? longint'(r.top) : longint'(kept_rects[k].top);
         hi_x = longint'(r.left) + longint'(r.width);
         if (longint'(kept_rects[k].left) + longint'(kept_rects[k].width) < hi_x)
            hi_x = longint'(kept_rects[k].left) + longint'(kept_rects[k].width);
         hi_y = longint'(r.top) + longint'(r.height);
         if (longint'(kept_rects[k].top) + longint'(kept_rects[k].height) < hi_y)
            hi_y = longint'(kept_rects[k].top) + longint'(kept_rects[k].height);
         // Touching or disjoint boxes have no overlap at all.
         inter  = (hi_x > lo_x && hi_y > lo_y) ? (hi_x - lo_x) * (hi_y - lo_y) : 0;
         area_k = longint'(kept_rects[k].width) * longint'(kept_rects[k].height);
         uni    = area_r + area_k - inter;
         if (inter * 256 > longint'(thr_now) * uni)
            keep_it = 1'b0;
      end
      v.keep      = keep_it;
      v.overflow  = 1'b0;
      v.box_index = frame_pos;
      // A survivor goes into the store; with the store full flag it and drop it.
      if (keep_it) begin
         if (kept_total < KEPT_DEPTH) begin
            kept_rects[kept_total] = r;
            kept_total++;
         end else begin
            v.overflow = 1'b1;
         end
      end
      if (frame_pos != gbn_pkg::INDEX_MAX)
         frame_pos++;
      return v;
   endfunction

   function automatic rect_type mk_rect(input int l, input int t, input int w, input int h);
      rect_type r;
      r.left   = CB'(l);
      r.top    = CB'(t);
      r.width  = CB'(w);
      r.height = CB'(h);
      return r;
   endfunction

   function automatic void set_idling(input int sender_pct, input int stall_pct);
      sender_idle_pct = sender_pct;
      rsp_stall_pct   = stall_pct;
   endfunction

   // Offer one box beat. Enter and leave on a falling edge; valid stays high
   // on exit so back-to-back beats follow without a gap.
   task automatic send_box(input logic fs, input rect_type r);
      gbn_pkg::gbn_result_type verdict;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_start <= fs;
      req_box_left    <= r.left;
      req_box_top     <= r.top;
      req_box_width   <= r.width;
      req_box_height  <= r.height;
      do @(posedge clock); while (req_stall);
      verdict          = judge_box(fs, r);
      pending_verdicts = {pending_verdicts, verdict};
      @(negedge clock);
   endtask

   // Drop valid and wait until every pending result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
   endtask

   // Write the threshold register; only ever done with the block idle.
   task automatic write_threshold(input logic [gbn_pkg::THR_W-1:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_iou_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      thr_now = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hand-picked frame under the reset threshold: duplicates, partial
   // overlaps, touching edges, zero-area boxes and coordinate extremes.
   task automatic test_basic_frame();
      send_box(1'b1, mk_rect(0, 0, 256, 256));
      send_box(1'b0, mk_rect(0, 0, 256, 256));
      send_box(1'b0, mk_rect(64, 0, 256, 256));
      send_box(1'b0, mk_rect(192, 0, 256, 256));
      send_box(1'b0, mk_rect(0, 256, 256, 256));
      send_box(1'b0, mk_rect(4000, 4000, 0, 0));
      send_box(1'b0, mk_rect(4000, 4000, 0, 0));
      send_box(1'b0, mk_rect(-32768, -32768, 65535, 65535));
      send_box(1'b0, mk_rect(32767, 32767, 65535, 65535));
      send_box(1'b0, mk_rect(-32768, 32767, 0, 65535));
      send_box(1'b1, mk_rect(32767, -32768, 65535, 0));
      send_box(1'b1, mk_rect(0, 0, 256, 256));
      send_box(1'b1, mk_rect(0, 0, 256, 256));
   endtask

   // IoU exactly at the threshold survives; one step lower it is dropped.
   task automatic test_threshold_boundary();
      write_threshold(9'd128);
      send_box(1'b1, mk_rect(0, 0, 32, 16));
      send_box(1'b0, mk_rect(0, 0, 16, 16));
      write_threshold(9'd127);
      send_box(1'b1, mk_rect(0, 0, 32, 16));
      send_box(1'b0, mk_rect(0, 0, 16, 16));
   endtask

   // Zero threshold kills any overlap but not zero-area pairs; 256 and above
   // never suppress.
   task automatic test_threshold_extremes();
      write_threshold(9'd0);
      send_box(1'b1, mk_rect(0, 0, 256, 256));
      send_box(1'b0, mk_rect(255, 255, 256, 256));
      send_box(1'b0, mk_rect(1000, 0, 0, 0));
      send_box(1'b0, mk_rect(1000, 0, 0, 0));
      write_threshold(9'd256);
      send_box(1'b1, mk_rect(0, 0, 256, 256));
      send_box(1'b0, mk_rect(0, 0, 256, 256));
      send_box(1'b0, mk_rect(0, 0, 256, 256));
      write_threshold(9'd511);
      send_box(1'b1, mk_rect(-500, -500, 900, 300));
      send_box(1'b0, mk_rect(-500, -500, 900, 300));
   endtask

   // Overrun the kept store with disjoint boxes, then re-send a stored and a
   // dropped box: the stored one suppresses, the dropped one cannot.
   task automatic test_store_full();
      write_threshold(gbn_pkg::IOU_THRESHOLD_RESET);
      for (int i = 0; i < KEPT_DEPTH + 6; i++)
         send_box(i == 0, mk_rect((i % 10) * 600 - 3000, (i / 10) * 600 - 3000, 400, 400));
      send_box(1'b0, mk_rect(-3000, -3000, 400, 400));
      send_box(1'b0, mk_rect(((KEPT_DEPTH + 4) % 10) * 600 - 3000,
                             ((KEPT_DEPTH + 4) / 10) * 600 - 3000, 400, 400));
   endtask

   // Hold the result side off for a long stretch while boxes keep coming, so
   // the output register fills and the input stalls.
   task automatic test_backpressure();
      set_idling(0, 0);
      drain();
      @(posedge clock);
      hold_cycles = HOLD_OFF;
      @(negedge clock);
      for (int i = 0; i < 24; i++)
         send_box(i == 0, mk_rect(int'($urandom_range(0, 3000)) - 1500,
                                  int'($urandom_range(0, 3000)) - 1500,
                                  int'($urandom_range(16, 800)),
                                  int'($urandom_range(16, 800))));
   endtask

   // Random frames of clustered boxes with some noise beats mixed in. Long
   // frames spread their boxes out so the store overruns now and then.
   task automatic run_random_frames(input int n_items);
      int       sent;
      int       len;
      int       n_clu;
      int       c;
      int       pick;
      int       spread;
      int       cx[80];
      int       cy[80];
      int       cs[80];
      rect_type r;
      logic     fs;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 85)
            len = $urandom_range(1, 16);
         else if (pick < 95)
            len = $urandom_range(17, 40);
         else
            len = $urandom_range(60, 80);
         n_clu  = (len > 50) ? len : $urandom_range(1, 4);
         spread = (len > 50) ? 30000 : 2000;
         for (int i = 0; i < n_clu; i++) begin
            cx[i] = int'($urandom_range(0, 2 * spread)) - spread;
            cy[i] = int'($urandom_range(0, 2 * spread)) - spread;
            cs[i] = (len > 50) ? $urandom_range(16, 400) : $urandom_range(16, 1500);
         end
         for (int b = 0; b < len; b++) begin
            if ($urandom_range(99) < 8) begin
               // Noise beat: any field value, frame start at random.
               r.left   = CB'($urandom);
               r.top    = CB'($urandom);
               r.width  = CB'($urandom);
               r.height = CB'($urandom);
               fs       = 1'($urandom_range(1));
            end else begin
               c        = (len > 50) ? b : $urandom_range(n_clu - 1);
               r.left   = CB'(cx[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4);
               r.top    = CB'(cy[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4);
               r.width  = CB'(cs[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4);
               r.height = CB'(cs[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4);
               fs       = (b == 0);
            end
            send_box(fs, r);
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      set_idling(0, 0);
      write_threshold(gbn_pkg::THR_W'($urandom_range(60, 180)));
      run_random_frames(75);
      set_idling(63, 0);
      write_threshold(gbn_pkg::THR_W'($urandom_range(0, 256)));
      run_random_frames(75);
      set_idling(0, 63);
      write_threshold(gbn_pkg::THR_W'($urandom_range(60, 180)));
      run_random_frames(75);
      set_idling(22, 22);
      write_threshold(gbn_pkg::THR_W'($urandom_range(60, 180)));
      run_random_frames(75);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_frame();
      test_threshold_boundary();
      test_threshold_extremes();
      test_store_full();
      test_backpressure();
      test_random_traffic();

      // Let stray beats show up before calling it.
      drain();
      repeat (KEPT_DEPTH + 20) @(negedge clock);
      if (fault_count == 0 && pending_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_kept_store.sv
hw/rtl/gbn_iou_unit.sv
hw/rtl/gbn_ctrl.sv
hw/rtl/greedy_box_nms.sv
hw/rtl/gbn_checker.sv
dv/testbench.sv
